### rtl/core/lfs_pkg.sv
`default_nettype none

package lfs_pkg;

    // Field widths of the request and result channels.
    localparam int OPCODE_W = 3;
    localparam int POWER_W  = 7;
    localparam int STATE_W  = 4;
    localparam int PULSE_W  = 12;
    localparam int LINK_W   = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 22;
    localparam int AUTO_W      = 22;

    // Timers.
    localparam int TIMER_BITS_DEFAULT = 22;
    localparam int COOLDOWN_MS        = 100;
    localparam int POWER_MAX          = 100;

    // Register reset values.
    localparam logic [15:0] SHOT_TIME_RST     = 16'd200;
    localparam logic [11:0] SERVO_NEUTRAL_RST = 12'd1500;
    localparam logic [9:0]  PUSH_OFFSET_RST   = 10'd500;
    localparam logic [9:0]  BRAKE_OFFSET_RST  = 10'd500;
    localparam logic [15:0] ARM_DELAY_RST     = 16'd2000;
    localparam logic [15:0] SPINUP_RST        = 16'd500;
    localparam logic [15:0] BRAKE_TIME_RST    = 16'd100;
    localparam logic [21:0] AUTO_DISARM_RST   = 22'd60000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHOT_TIME     = 3'd0,
        REG_SERVO_NEUTRAL = 3'd1,
        REG_PUSH_OFFSET   = 3'd2,
        REG_BRAKE_OFFSET  = 3'd3,
        REG_ARM_DELAY     = 3'd4,
        REG_SPINUP        = 3'd5,
        REG_BRAKE_TIME    = 3'd6,
        REG_AUTO_DISARM   = 3'd7
    } reg_idx_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 3'd0,
        OP_ACTIVITY  = 3'd1,
        OP_ARM       = 3'd2,
        OP_DISARM    = 3'd3,
        OP_FIRE      = 3'd4,
        OP_ESC_TEST  = 3'd5,
        OP_CALIBRATE = 3'd6
    } op_t;

    typedef enum logic [STATE_W-1:0] {
        MODE_IDLE      = 4'd0,
        MODE_ARMING    = 4'd1,
        MODE_ARMED     = 4'd2,
        MODE_DISARMING = 4'd3,
        MODE_DISARMED  = 4'd4,
        MODE_SPINUP    = 4'd5,
        MODE_PUSH      = 4'd6,
        MODE_BRAKE     = 4'd7,
        MODE_COOLDOWN  = 4'd8,
        MODE_ESC_TEST  = 4'd9,
        MODE_CALIB     = 4'd10
    } mode_t;

    typedef enum logic [LINK_W-1:0] {
        LINK_NONE   = 2'd0,
        LINK_ATTACH = 2'd1,
        LINK_DETACH = 2'd2
    } link_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0]       shot_time_ms;
        logic [11:0]       servo_neutral_us;
        logic [9:0]        push_offset_us;
        logic [9:0]        brake_offset_us;
        logic [15:0]       arm_wait_ms;
        logic [15:0]       spin_wait_ms;
        logic [15:0]       brake_hold_ms;
        logic [AUTO_W-1:0] idle_limit_ms;
    } cfg_t;

    // One result item.
    typedef struct packed {
        mode_t              state;
        logic               armed;
        logic               can_fire;
        logic               flywheel_update;
        logic [POWER_W-1:0] flywheel_power;
        logic               servo_update;
        logic [PULSE_W-1:0] servo_pulse_us;
        link_t              esc_link;
        link_t              pusher_link;
        logic               arm_first_error;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/lfs_ifs.sv
`default_nettype none

// Request channel: one event per request.
interface lfs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [lfs_pkg::OPCODE_W-1:0] opcode;
    logic [lfs_pkg::POWER_W-1:0]  power;

    modport source (output valid, output opcode, output power, input ready);
    modport sink (input valid, input opcode, input power, output ready);
endinterface

// Result channel: one result per request.
interface lfs_res_if;
    logic                         valid;
    logic                         ready;
    logic [lfs_pkg::STATE_W-1:0]  state;
    logic                         armed;
    logic                         can_fire;
    logic                         flywheel_update;
    logic [lfs_pkg::POWER_W-1:0]  flywheel_power;
    logic                         servo_update;
    logic [lfs_pkg::PULSE_W-1:0]  servo_pulse_us;
    logic [lfs_pkg::LINK_W-1:0]   esc_link;
    logic [lfs_pkg::LINK_W-1:0]   pusher_link;
    logic                         arm_first_error;

    modport source (
        output valid, output state, output armed, output can_fire,
        output flywheel_update, output flywheel_power, output servo_update,
        output servo_pulse_us, output esc_link, output pusher_link,
        output arm_first_error, input ready
    );
    modport sink (
        input valid, input state, input armed, input can_fire,
        input flywheel_update, input flywheel_power, input servo_update,
        input servo_pulse_us, input esc_link, input pusher_link,
        input arm_first_error, output ready
    );
endinterface

`default_nettype wire

### rtl/core/lfs_cfg.sv
`default_nettype none

module lfs_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output lfs_pkg::cfg_t                         cfg
);

    lfs_pkg::cfg_t cfg_reg;
    lfs_pkg::cfg_t cfg_next;

    // Decode the register index; each write keeps the low bits of the data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (lfs_pkg::reg_idx_t'(cfg_index))
                lfs_pkg::REG_SHOT_TIME:     cfg_next.shot_time_ms     = cfg_wdata[15:0];
                lfs_pkg::REG_SERVO_NEUTRAL: cfg_next.servo_neutral_us = cfg_wdata[11:0];
                lfs_pkg::REG_PUSH_OFFSET:   cfg_next.push_offset_us   = cfg_wdata[9:0];
                lfs_pkg::REG_BRAKE_OFFSET:  cfg_next.brake_offset_us  = cfg_wdata[9:0];
                lfs_pkg::REG_ARM_DELAY:     cfg_next.arm_wait_ms      = cfg_wdata[15:0];
                lfs_pkg::REG_SPINUP:        cfg_next.spin_wait_ms     = cfg_wdata[15:0];
                lfs_pkg::REG_BRAKE_TIME:    cfg_next.brake_hold_ms    = cfg_wdata[15:0];
                lfs_pkg::REG_AUTO_DISARM:
                    cfg_next.idle_limit_ms = cfg_wdata[lfs_pkg::AUTO_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with its reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shot_time_ms     <= lfs_pkg::SHOT_TIME_RST;
            cfg_reg.servo_neutral_us <= lfs_pkg::SERVO_NEUTRAL_RST;
            cfg_reg.push_offset_us   <= lfs_pkg::PUSH_OFFSET_RST;
            cfg_reg.brake_offset_us  <= lfs_pkg::BRAKE_OFFSET_RST;
            cfg_reg.arm_wait_ms      <= lfs_pkg::ARM_DELAY_RST;
            cfg_reg.spin_wait_ms     <= lfs_pkg::SPINUP_RST;
            cfg_reg.brake_hold_ms    <= lfs_pkg::BRAKE_TIME_RST;
            cfg_reg.idle_limit_ms    <= lfs_pkg::AUTO_DISARM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/lfs_engine.sv
`default_nettype none

module lfs_engine #(
    parameter int TIMER_BITS = lfs_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [lfs_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [lfs_pkg::POWER_W-1:0]   power,
    input  wire lfs_pkg::cfg_t                 cfg,
    output lfs_pkg::res_t                      res
);

    // Compare width wide enough for both the timers and the widest limit.
    localparam int CMP_W = (TIMER_BITS > lfs_pkg::AUTO_W) ? TIMER_BITS : lfs_pkg::AUTO_W;

    lfs_pkg::mode_t          mode_reg, mode_next;
    logic                    armed_reg, armed_next;
    logic [TIMER_BITS-1:0]   tim_reg, tim_next;
    logic [TIMER_BITS-1:0]   tsa_reg, tsa_next;
    logic [lfs_pkg::POWER_W-1:0] held_reg, held_next;

    lfs_pkg::mode_t          mode_a;
    lfs_pkg::mode_t          target;
    logic [TIMER_BITS-1:0]   tim_a;
    logic [TIMER_BITS-1:0]   tsa_a;
    logic [lfs_pkg::POWER_W-1:0] pw_clamped;
    logic [CMP_W-1:0]        tim_cmp;
    logic [CMP_W-1:0]        tsa_cmp;
    logic [lfs_pkg::PULSE_W:0]   push_sum;
    logic [lfs_pkg::PULSE_W-1:0] brake_sub;
    logic                    idle_or_armed;

    assign pw_clamped = (power > lfs_pkg::POWER_W'(lfs_pkg::POWER_MAX))
                        ? lfs_pkg::POWER_W'(lfs_pkg::POWER_MAX) : power;

    // Servo pulse targets: push saturates high, brake saturates at zero.
    assign push_sum  = {1'b0, cfg.servo_neutral_us}
                       + (lfs_pkg::PULSE_W + 1)'(cfg.push_offset_us);
    assign brake_sub = (cfg.servo_neutral_us >= lfs_pkg::PULSE_W'(cfg.brake_offset_us))
                       ? cfg.servo_neutral_us - lfs_pkg::PULSE_W'(cfg.brake_offset_us)
                       : '0;

    // Command step, timed step and entry actions for one event.
    always_comb
    begin
        mode_a        = mode_reg;
        target        = mode_reg;
        tim_a         = tim_reg;
        tsa_a         = tsa_reg;
        held_next     = held_reg;
        armed_next    = armed_reg;
        mode_next     = mode_reg;
        tim_next      = tim_reg;
        tsa_next      = tsa_reg;
        tim_cmp       = '0;
        tsa_cmp       = '0;
        idle_or_armed = 1'b0;
        res           = '0;

        // A tick advances both timers, saturating.
        if (lfs_pkg::op_t'(opcode) == lfs_pkg::OP_TICK)
        begin
            tim_a = (tim_reg == '1) ? tim_reg : tim_reg + TIMER_BITS'(1);
            tsa_a = (tsa_reg == '1) ? tsa_reg : tsa_reg + TIMER_BITS'(1);
        end

        // Command step.
        unique case (lfs_pkg::op_t'(opcode))
            lfs_pkg::OP_ACTIVITY:
            begin
                tsa_a = '0;
            end
            lfs_pkg::OP_ARM:
            begin
                tsa_a = '0;
                if (!armed_reg && mode_reg != lfs_pkg::MODE_ARMING)
                begin
                    target = lfs_pkg::MODE_ARMING;
                end
            end
            lfs_pkg::OP_DISARM:
            begin
                tim_a = '0;
                if (mode_reg == lfs_pkg::MODE_CALIB)
                begin
                    mode_a = lfs_pkg::MODE_IDLE;
                    target = lfs_pkg::MODE_IDLE;
                end
                else
                begin
                    target = lfs_pkg::MODE_DISARMING;
                end
            end
            lfs_pkg::OP_FIRE:
            begin
                if (!armed_reg)
                begin
                    res.arm_first_error = 1'b1;
                end
                else if (mode_reg == lfs_pkg::MODE_ARMED || mode_reg == lfs_pkg::MODE_IDLE)
                begin
                    held_next = pw_clamped;
                    target    = lfs_pkg::MODE_SPINUP;
                    tsa_a     = '0;
                end
            end
            lfs_pkg::OP_ESC_TEST:
            begin
                if (!armed_reg)
                begin
                    res.arm_first_error = 1'b1;
                end
                else
                begin
                    held_next = pw_clamped;
                    target    = lfs_pkg::MODE_ESC_TEST;
                    tim_a     = '0;
                    tsa_a     = '0;
                end
            end
            lfs_pkg::OP_CALIBRATE:
            begin
                if (!armed_reg)
                begin
                    res.arm_first_error = 1'b1;
                end
                else
                begin
                    res.esc_link = lfs_pkg::LINK_ATTACH;
                    if (mode_reg != lfs_pkg::MODE_CALIB)
                    begin
                        tim_a = '0;
                    end
                    mode_a = lfs_pkg::MODE_CALIB;
                    target = lfs_pkg::MODE_CALIB;
                end
            end
            default:
            begin
                target = mode_reg;
            end
        endcase

        // Timed step, only when the command left the mode alone.
        tim_cmp       = CMP_W'(tim_a);
        tsa_cmp       = CMP_W'(tsa_a);
        idle_or_armed = (mode_a == lfs_pkg::MODE_IDLE) || (mode_a == lfs_pkg::MODE_ARMED);
        if (target == mode_a)
        begin
            if (armed_reg && idle_or_armed && tsa_cmp > CMP_W'(cfg.idle_limit_ms))
            begin
                target = lfs_pkg::MODE_DISARMING;
            end
            else
            begin
                unique case (mode_a)
                    lfs_pkg::MODE_ARMING:
                        if (tim_cmp >= CMP_W'(cfg.arm_wait_ms))
                            target = lfs_pkg::MODE_ARMED;
                    lfs_pkg::MODE_DISARMING:
                        target = lfs_pkg::MODE_DISARMED;
                    lfs_pkg::MODE_SPINUP:
                        if (tim_cmp >= CMP_W'(cfg.spin_wait_ms))
                            target = lfs_pkg::MODE_PUSH;
                    lfs_pkg::MODE_PUSH:
                        if (tim_cmp >= CMP_W'(cfg.shot_time_ms))
                            target = lfs_pkg::MODE_BRAKE;
                    lfs_pkg::MODE_BRAKE:
                        if (tim_cmp >= CMP_W'(cfg.brake_hold_ms))
                            target = lfs_pkg::MODE_COOLDOWN;
                    lfs_pkg::MODE_COOLDOWN:
                        if (tim_cmp >= CMP_W'(lfs_pkg::COOLDOWN_MS))
                            target = lfs_pkg::MODE_ARMED;
                    default:
                        target = mode_a;
                endcase
            end
        end

        // Entry actions of the new mode.
        mode_next = mode_a;
        tim_next  = tim_a;
        tsa_next  = tsa_a;
        if (target != mode_a)
        begin
            mode_next = target;
            tim_next  = '0;
            unique case (target)
                lfs_pkg::MODE_ARMING:
                    res.esc_link = lfs_pkg::LINK_ATTACH;
                lfs_pkg::MODE_ARMED:
                    armed_next = 1'b1;
                lfs_pkg::MODE_DISARMING:
                    armed_next = 1'b0;
                lfs_pkg::MODE_DISARMED:
                begin
                    res.esc_link    = lfs_pkg::LINK_DETACH;
                    res.pusher_link = lfs_pkg::LINK_DETACH;
                end
                lfs_pkg::MODE_SPINUP, lfs_pkg::MODE_ESC_TEST:
                begin
                    res.flywheel_update = 1'b1;
                    res.flywheel_power  = held_next;
                end
                lfs_pkg::MODE_PUSH:
                begin
                    res.pusher_link    = lfs_pkg::LINK_ATTACH;
                    res.servo_update   = 1'b1;
                    res.servo_pulse_us = push_sum[lfs_pkg::PULSE_W]
                                         ? '1 : push_sum[lfs_pkg::PULSE_W-1:0];
                end
                lfs_pkg::MODE_BRAKE:
                begin
                    res.servo_update   = 1'b1;
                    res.servo_pulse_us = brake_sub;
                end
                lfs_pkg::MODE_COOLDOWN:
                begin
                    res.servo_update    = 1'b1;
                    res.servo_pulse_us  = cfg.servo_neutral_us;
                    res.flywheel_update = 1'b1;
                    res.flywheel_power  = '0;
                end
                default:
                    armed_next = armed_reg;
            endcase
        end

        res.state    = mode_next;
        res.armed    = armed_next;
        res.can_fire = armed_next && (mode_next == lfs_pkg::MODE_IDLE
                                      || mode_next == lfs_pkg::MODE_ARMED);
    end

    // Sequencer state, updated once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lfs_pkg::MODE_IDLE;
            armed_reg <= 1'b0;
            tim_reg   <= '0;
            tsa_reg   <= '0;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            armed_reg <= armed_next;
            tim_reg   <= tim_next;
            tsa_reg   <= tsa_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/launcher_firing_sequencer.sv
`default_nettype none

// Channel  Dir  Contents                                  Handshake
// cmd      in   opcode, power                             valid/ready
// res      out  state, armed, can_fire, flywheel, servo,  valid/ready
//               esc/pusher link, arm_first_error
// cfg      in   cfg_index, cfg_wdata                      cfg_we, no stall
//
// One request per clock is taken while cmd.ready is high.
// The request register and the result register each hold one item, so the block
// keeps taking requests while a finished result waits; cmd.ready drops only when
// both are full and res.ready is low. The sequencer state advances when the
// request register hands its item to the result register. Reset is asynchronous
// and puts the sequencer in idle, disarmed, with the config registers at defaults.

module launcher_firing_sequencer #(
    parameter int TIMER_BITS = lfs_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    lfs_cmd_if.sink                               cmd,
    lfs_res_if.source                             res,
    input  wire logic                             cfg_we,
    input  wire logic [lfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    lfs_pkg::cfg_t                cfg;
    lfs_pkg::res_t                step_res;

    logic                         req_valid_reg, req_valid_next;
    logic [lfs_pkg::OPCODE_W-1:0] req_op_reg;
    logic [lfs_pkg::POWER_W-1:0]  req_pw_reg;
    logic                         out_valid_reg, out_valid_next;
    lfs_pkg::res_t                out_res_reg;

    logic                         out_free;
    logic                         advance;
    logic                         load;

    lfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfs_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .opcode  (req_op_reg),
        .power   (req_pw_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Flow control between the request register and the result register.
    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = req_valid_reg && out_free;
    assign cmd.ready = !req_valid_reg || out_free;
    assign load      = cmd.valid && cmd.ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (load)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_op_reg <= cmd.opcode;
            req_pw_reg <= cmd.power;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    // Result channel.
    assign res.valid           = out_valid_reg;
    assign res.state           = out_res_reg.state;
    assign res.armed           = out_res_reg.armed;
    assign res.can_fire        = out_res_reg.can_fire;
    assign res.flywheel_update = out_res_reg.flywheel_update;
    assign res.flywheel_power  = out_res_reg.flywheel_power;
    assign res.servo_update    = out_res_reg.servo_update;
    assign res.servo_pulse_us  = out_res_reg.servo_pulse_us;
    assign res.esc_link        = out_res_reg.esc_link;
    assign res.pusher_link     = out_res_reg.pusher_link;
    assign res.arm_first_error = out_res_reg.arm_first_error;

endmodule

`default_nettype wire
